// ===== rtl/sop_pkg.sv =====
// Shared types and constants for the scaled outer product block.
`timescale 1ns / 1ps
`default_nettype none

package sop_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned BIDX_W      = 6;
  localparam int unsigned ALPHA_W     = 16;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  // Register reset values
  localparam logic signed [ALPHA_W-1:0] ALPHA_RESET = 16'sd4096;
  localparam logic [LEN_W-1:0]          BLEN_RESET  = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEN  = 1'b1;

  // Input item kinds (tuser)
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_b;     // write the request's sample into the b store
    logic row_mul;    // capture alpha * sample
    logic scale_ld;   // saturate scaled value, clear column counter
    logic issue;      // read the current column, advance the counter
  } sop_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic adv;        // pipeline moves this cycle
    logic s1_busy;    // read stage still holds a column
    logic len_zero;   // effective row length is zero
    logic col_last;   // column counter is on the last column
  } sop_status_t;

endpackage

`default_nettype wire

// ===== rtl/sop_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sop_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sop_ctrl.sv =====
// Controller state machine: accepts requests and sequences the columns of a row.
`timescale 1ns / 1ps
`default_nettype none

module sop_ctrl
  import sop_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_kind_i,
  output      logic        in_ready_o,
  output      sop_cmd_t    cmd_o,
  input  wire sop_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCALE = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_ROW) begin
            cmd_o.row_mul = 1'b1;
            state_d       = ST_SCALE;
          end else begin
            cmd_o.load_b = 1'b1;
          end
        end
      end
      ST_SCALE: begin
        // scaled value is shared by the read stage; wait for it to drain
        if (status_i.len_zero) begin
          state_d = ST_IDLE;
        end else if (!status_i.s1_busy) begin
          cmd_o.scale_ld = 1'b1;
          state_d        = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = status_i.adv;
        if (status_i.adv && status_i.col_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sop_dp.sv =====
// Datapath: config registers, scaling, b store, column counter and product stage.
`timescale 1ns / 1ps
`default_nettype none

module sop_dp
  import sop_pkg::*;
#(
  parameter int unsigned MAX_B_LEN = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic [BIDX_W-1:0]          b_index_i,
  input  wire sop_cmd_t                   cmd_i,
  output      sop_status_t                status_o,
  input  wire logic                       out_ready_i,
  output      logic                       out_valid_o,
  output      logic signed [PROD_W-1:0]   product_o,
  output      logic [COL_W-1:0]           column_o,
  output      logic                       row_end_o
);

  localparam int unsigned AW      = $clog2(MAX_B_LEN);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_B_LEN);

  // Configuration registers
  logic signed [ALPHA_W-1:0] alpha_q;
  logic [LEN_W-1:0]          blen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      blen_q  <= BLEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA: alpha_q <= $signed(cfg_data_i[ALPHA_W-1:0]);
        CFG_BLEN:  blen_q  <= cfg_data_i[LEN_W-1:0];
        default:   ;
      endcase
    end
  end

  logic [LEN_W-1:0] len_eff;
  assign len_eff = (blen_q > MaxLen) ? MaxLen : blen_q;

  // Scaling: Q4.12 * Q1.15, floor shift by 12, saturate to 16 bits
  logic signed [PROD_W-1:0]   p_q;
  logic signed [SAMPLE_W-1:0] scaled_q;
  logic signed [PROD_W-13:0]  p_sh;
  logic signed [SAMPLE_W-1:0] scaled_d;

  assign p_sh = p_q[PROD_W-1:12];

  always_comb begin
    if (!p_sh[PROD_W-13] && (p_sh[PROD_W-14:SAMPLE_W-1] != '0)) begin
      scaled_d = 16'sh7FFF;
    end else if (p_sh[PROD_W-13] && (p_sh[PROD_W-14:SAMPLE_W-1] != '1)) begin
      scaled_d = -16'sh8000;
    end else begin
      scaled_d = p_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_mul) begin
      p_q <= PROD_W'(alpha_q) * PROD_W'(sample_i);
    end
    if (cmd_i.scale_ld) begin
      scaled_q <= scaled_d;
    end
  end

  // Column counter
  logic [AW-1:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (cmd_i.scale_ld) begin
      col_q <= '0;
    end else if (cmd_i.issue) begin
      col_q <= col_q + AW'(1);
    end
  end

  // b store
  logic                       ram_we;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic                       adv;

  assign ram_we = cmd_i.load_b && ({1'b0, b_index_i} < MaxLen);

  sop_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_B_LEN)
  ) i_bstore (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(b_index_i[AW-1:0]),
    .wdata_i(sample_i),
    .re_i   (adv),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  // Read stage and output register; both move together when output is free
  logic                     v1_q;
  logic [AW-1:0]            col1_q;
  logic                     last1_q;
  logic                     out_valid_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [COL_W-1:0]         col_out_q;
  logic                     last_out_q;
  logic                     col_last;

  assign adv      = !out_valid_q || out_ready_i;
  assign col_last = (LEN_W'(col_q) == (len_eff - LEN_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= cmd_i.issue;
      out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col1_q  <= col_q;
      last1_q <= col_last;
      if (v1_q) begin
        prod_q     <= PROD_W'(scaled_q) * PROD_W'($signed(ram_rdata));
        col_out_q  <= COL_W'(col1_q);
        last_out_q <= last1_q;
      end
    end
  end

  assign status_o.adv      = adv;
  assign status_o.s1_busy  = v1_q;
  assign status_o.len_zero = (len_eff == '0);
  assign status_o.col_last = col_last;

  assign out_valid_o = out_valid_q;
  assign product_o   = prod_q;
  assign column_o    = col_out_q;
  assign row_end_o   = last_out_q;

endmodule

`default_nettype wire

// ===== rtl/scaled_outer_product.sv =====
// Top level of the scaled outer product block.
`timescale 1ns / 1ps
`default_nettype none

// Streaming scaled outer product R[i][j] = alpha * a[i] * b[j] in fixed point.
// A load request (tuser = 0) writes sample into the b store at b_index; an index
// at or above MAX_B_LEN is dropped. A row request (tuser = 1) carries one a
// element: it is scaled by alpha (Q4.12), floored by 12 bits and saturated to
// 16 bits, then multiplied by b[0] .. b[len-1], with len = b_length capped at
// MAX_B_LEN. Each result is the full 32-bit signed product, its column, and
// tlast on the last column; b_length of 0 gives no results. Every b entry a row
// reads must have been loaded first. A load request keeps the block idle, so the
// next request can follow at once. A row request is accepted while idle and
// captures alpha * a; the scale step saturates it, then one column per cycle is
// read from the b store's single read port while the output can move; the input
// is held off until the row is issued. Results pass the read stage and output
// register and leave one per cycle when the sink is ready. Downstream stalls stop
// the column sequencer. Since the scaled value is shared, a new row waits in its
// scale step until the previous row's last column has left the read stage.
// The output register frees the input side while a final result still waits.
// Configuration: cfg_idx_i 0 = alpha, 1 = b_length; write only while idle.

module scaled_outer_product
  import sop_pkg::*;
#(
  parameter int unsigned MAX_B_LEN = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // sample[15:0], b_index[21:16], pad
  input  wire logic [0:0]             s_axis_tuser_i,  // kind[0]
  // result stream
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // product[31:0], column[37:32], pad
  output      logic                   m_axis_tlast_o   // row_end
);

  sop_cmd_t    cmd;
  sop_status_t status;

  logic signed [PROD_W-1:0] product;
  logic [COL_W-1:0]         column;

  sop_ctrl i_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_kind_i (s_axis_tuser_i[0]),
    .in_ready_o(s_axis_tready_o),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  sop_dp #(
    .MAX_B_LEN(MAX_B_LEN)
  ) i_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   ($signed(s_axis_tdata_i[SAMPLE_W-1:0])),
    .b_index_i  (s_axis_tdata_i[SAMPLE_W+BIDX_W-1:SAMPLE_W]),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .product_o  (product),
    .column_o   (column),
    .row_end_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - PROD_W - COL_W)'(0), column, product};

endmodule

`default_nettype wire

// ===== rtl/sop_checker.sv =====
// Port-level assertions for the scaled outer product block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sop_checker
  import sop_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic [0:0]             s_axis_tuser_i,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                   m_axis_tlast_o
);

  // A stalled result keeps its data and last flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // A row request always occupies the sequencer for its scale step
  a_row_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == KIND_ROW)) |=>
      !s_axis_tready_o)
    else $error("input ready right after a row request");

  // A load request leaves the input ready in the following cycle
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == KIND_LOAD)) |=>
      s_axis_tready_o)
    else $error("input stalled after a load request");

endmodule

bind scaled_outer_product sop_checker i_sop_checker (.*);

`default_nettype wire

// ===== tb/scaled_outer_product_test.sv =====
// Self-checking testbench for the scaled outer product block.
`timescale 1ns / 1ps

module scaled_outer_product_test;
  import sop_pkg::*;

  localparam int unsigned B_DEPTH   = 64;
  localparam int unsigned DRAIN_CYC = 16;    // drain margin; rows end with their last result
  localparam int unsigned LONG_HOLD = 400;   // sink back-pressure stretch
  localparam int unsigned STALL_MAX = 4000;  // cycles with no request moving on any port

  // one input request, as it travels on the slave side
  typedef struct packed {
    logic                        kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [BIDX_W-1:0]           b_index;
  } request_t;

  // one result, as it travels on the master side
  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic [COL_W-1:0]         column;
    logic                     row_end;
  } result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // sample[15:0], b_index[21:16], pad
  logic [0:0]             s_axis_tuser_i;   // kind[0]
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // product[31:0], column[37:32], pad
  logic                   m_axis_tlast_o;   // row_end

  scaled_outer_product #(
    .MAX_B_LEN(B_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // shadow of the block: registers and b store
  logic signed [ALPHA_W-1:0]  alpha_q;
  logic [LEN_W-1:0]           blen_q;
  logic signed [SAMPLE_W-1:0] b_mirror [B_DEPTH];

  request_t requests_to_send [$];   // filled by the sequencer, drained by the driver
  result_t  products_due [$];       // predicted results, oldest first
  request_t req_on_bus;             // request currently offered
  bit [B_DEPTH-1:0] b_queued;       // store entries that some queued load writes

  int unsigned sender_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_token;          // bump to ask the sink for a long hold-off
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned mismatch_cnt;
  int unsigned loads_taken;
  int unsigned rows_taken;
  int unsigned results_seen;
  int unsigned cfg_writes;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  // clock and reset
  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_ALPHA;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_LOAD;
    m_axis_tready_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // alpha * a in Q4.12 x Q1.15, floored by 12 bits, clipped to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] scale_sample(logic signed [SAMPLE_W-1:0] a);
    logic signed [31:0] p;
    logic signed [31:0] q;
    p = 32'(alpha_q) * 32'(a);
    q = p >>> 12;
    if (q > 32'sd32767) q = 32'sd32767;
    if (q < -32'sd32768) q = -32'sd32768;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic int unsigned row_length();
    return (blen_q > B_DEPTH) ? B_DEPTH : 32'(blen_q);
  endfunction

  // update the shadow for one accepted request and queue the row it produces
  task automatic apply_request(request_t r);
    logic signed [SAMPLE_W-1:0] scaled;
    int unsigned len;
    result_t res;
    if (r.kind == KIND_LOAD) begin
      b_mirror[r.b_index] = r.sample;
    end else begin
      len    = row_length();
      scaled = scale_sample(r.sample);
      for (int unsigned j = 0; j < len; j++) begin
        res.product = PROD_W'(scaled) * PROD_W'(b_mirror[j]);
        res.column  = j[COL_W-1:0];
        res.row_end = (j + 1 == len);
        products_due.push_back(res);
      end
    end
  endtask

  task automatic flag_mismatch(string what);
    if (mismatch_cnt < 40) $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // driver: offers queued requests, holds a request until it is taken
  always @(posedge clk_i) begin : drv
    logic stuck;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        apply_request(req_on_bus);
        if (req_on_bus.kind == KIND_LOAD) loads_taken++;
        else rows_taken++;
      end
      stuck = s_axis_tvalid_i && !s_axis_tready_o;
      if (!stuck) begin
        if (requests_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_on_bus = requests_to_send.pop_front();
          s_axis_tdata_i  <= {{(IN_TDATA_W-SAMPLE_W-BIDX_W){1'b0}},
                              req_on_bus.b_index, req_on_bus.sample};
          s_axis_tuser_i  <= req_on_bus.kind;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every result against the oldest prediction, drives tready
  always @(posedge clk_i) begin : mon
    result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (products_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result product=%0d column=%0d",
                                  $signed(m_axis_tdata_o[31:0]), m_axis_tdata_o[37:32]));
        end else begin
          want = products_due.pop_front();
          if (m_axis_tdata_o[31:0] !== want.product)
            flag_mismatch($sformatf("column %0d product %0d, expected %0d", want.column,
                                    $signed(m_axis_tdata_o[31:0]), want.product));
          if (m_axis_tdata_o[37:32] !== want.column)
            flag_mismatch($sformatf("column %0d, expected %0d",
                                    m_axis_tdata_o[37:32], want.column));
          if (m_axis_tlast_o !== want.row_end)
            flag_mismatch($sformatf("column %0d tlast %b, expected %b",
                                    want.column, m_axis_tlast_o, want.row_end));
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // watchdog: nothing moving on any port for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("[%0t] timeout: no request moved for %0d cycles", $realtime, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] any_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SAMPLE_W'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic queue_request(logic kind, logic signed [SAMPLE_W-1:0] v, int unsigned idx);
    request_t r;
    r.kind    = kind;
    r.sample  = v;
    r.b_index = idx[BIDX_W-1:0];
    if (kind == KIND_LOAD) b_queued[idx] = 1'b1;
    requests_to_send.push_back(r);
  endtask

  task automatic queue_row(logic signed [SAMPLE_W-1:0] v);
    queue_request(KIND_ROW, v, $urandom_range(B_DEPTH-1));
  endtask

  // everything sent, every result back, then a drain margin
  task automatic wait_drained();
    do @(negedge clk_i);
    while (requests_to_send.size() != 0 || s_axis_tvalid_i || products_due.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic apply_config(logic signed [ALPHA_W-1:0] a, logic [LEN_W-1:0] len);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ALPHA;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BLEN;
    cfg_data_i <= {{(CFG_DATA_W-LEN_W){1'b0}}, len};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    alpha_q = a;
    blen_q  = len;
    cfg_writes += 2;
    settings_used++;
    @(negedge clk_i);
  endtask

  // random traffic under one setting; store entries a row will read get loaded first
  task automatic random_phase(logic signed [ALPHA_W-1:0] a, logic [LEN_W-1:0] len,
                              int unsigned n, bit pause_midway, bit long_hold);
    int unsigned eff;
    apply_config(a, len);
    eff = (len > B_DEPTH) ? B_DEPTH : len;
    for (int unsigned j = 0; j < eff; j++)
      if (!b_queued[j]) queue_request(KIND_LOAD, any_sample(), j);
    for (int unsigned k = 0; k < n; k++) begin
      // sender stops here until the block has returned every result
      if (pause_midway && k == n / 2) wait_drained();
      if ($urandom_range(99) < 35) queue_request(KIND_LOAD, any_sample(), $urandom_range(B_DEPTH-1));
      else queue_row(any_sample());
    end
    if (long_hold) hold_token++;
  endtask

  initial begin
    alpha_q         = ALPHA_RESET;
    blen_q          = BLEN_RESET;
    b_queued        = '0;
    hold_token      = 0;
    hold_seen       = 0;
    hold_left       = 0;
    mismatch_cnt    = 0;
    loads_taken     = 0;
    rows_taken      = 0;
    results_seen    = 0;
    cfg_writes      = 0;
    settings_used   = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 10;
    sink_idle_pct   = 55;
    for (int unsigned j = 0; j < B_DEPTH; j++) b_mirror[j] = '0;
    @(posedge rst_ni);

    // directed: unity scale, extreme b values, top store index
    apply_config(16'sd4096, 7'd4);
    queue_request(KIND_LOAD, 16'sh7fff, 0);
    queue_request(KIND_LOAD, 16'sh8000, 1);
    queue_request(KIND_LOAD, 16'shffff, 2);
    queue_request(KIND_LOAD, 16'sh0000, 3);
    queue_request(KIND_LOAD, 16'sh0001, B_DEPTH - 1);
    queue_row(16'sh7fff);
    queue_row(16'sh8000);
    queue_row(16'sh0001);
    queue_row(16'shffff);
    queue_row(16'sh0000);
    // largest positive alpha: scaled value overflows and clips
    apply_config(16'sh7fff, 7'd2);
    queue_row(16'sh7fff);
    queue_row(16'sh8000);
    queue_row(16'sh0008);
    queue_row(16'shffff);
    // most negative alpha: -8 * -1.0 clips high
    apply_config(16'sh8000, 7'd1);
    queue_row(16'sh8000);
    queue_row(16'sh7fff);
    queue_row(16'shffff);
    // zero length: rows give nothing
    apply_config(-16'sd1, 7'd0);
    queue_row(16'sh0005);
    queue_row(-16'sd5);
    // floor rounding of small negative products
    apply_config(16'sd4095, 7'd3);
    queue_row(16'shffff);
    queue_row(16'sh0001);

    // random: sender idles little, sink a lot
    random_phase(16'sd4096, 7'd64, 32, 1'b0, 1'b0);
    random_phase(16'sh8000, 7'd8, 32, 1'b0, 1'b0);
    random_phase(16'sh7fff, 7'd64, 32, 1'b0, 1'b1);
    random_phase(ALPHA_W'($urandom_range(16'hffff)), 7'd127, 32, 1'b0, 1'b0);
    // the other way round
    wait_drained();
    sender_idle_pct = 55;
    sink_idle_pct   = 10;
    random_phase(16'sd0, 7'd3, 32, 1'b0, 1'b0);
    random_phase(ALPHA_W'($urandom_range(16'hffff)), 7'd1, 32, 1'b1, 1'b0);
    random_phase(-16'sd4096, 7'd0, 32, 1'b0, 1'b0);
    random_phase(ALPHA_W'($urandom_range(16'hffff)), 7'd65, 32, 1'b0, 1'b0);
    // no idling at all
    wait_drained();
    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    random_phase(ALPHA_W'($urandom_range(16'hffff)), LEN_W'($urandom_range(1, 16)), 32,
                 1'b0, 1'b0);
    random_phase(16'sh7fff, 7'd16, 32, 1'b0, 1'b0);
    random_phase(16'sh8000, 7'd64, 32, 1'b0, 1'b1);
    random_phase(ALPHA_W'($urandom_range(16'hffff)), LEN_W'($urandom_range(2, 10)), 32,
                 1'b0, 1'b0);
    wait_drained();

    $display("covered %0d loads and %0d rows, %0d results checked", loads_taken, rows_taken,
             results_seen);
    $display("%0d register writes over %0d settings, incl. clipping scales, zero and long rows",
             cfg_writes, settings_used);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
